[hw/rtl/buddy_pkg.sv]
// Shared types and codes of the buddy allocator.
`default_nettype none
package buddy_pkg;

    localparam int OWNER_W = 16;
    localparam int SIZE_W  = 17;
    localparam int ADDR_W  = 32;

    typedef logic [1:0] t_node_st;
    localparam t_node_st NODE_FREE     = 2'd0;
    localparam t_node_st NODE_OCCUPIED = 2'd1;
    localparam t_node_st NODE_SPLIT    = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status STS_OK       = 2'd0;
    localparam t_status STS_NO_SPACE = 2'd1;
    localparam t_status STS_INVALID  = 2'd2;

    // front end to tree walker
    typedef struct packed {
        logic start;
        logic ack;
    } t_walk_ctl;

    // tree walker to front end
    typedef struct packed {
        logic ready;
        logic done;
        logic found;
    } t_walk_sts;

endpackage
`default_nettype wire

[hw/rtl/buddy_allocator_first_fit.sv]
// Top level of the buddy allocator: argument check, size rounding, address and result register.
//
//   channel   direction  handshake                  payload
//   request   in         i_req_valid / o_req_stall  i_owner_id, i_request_size
//   response  out        o_rsp_valid / i_rsp_stall  o_block_address, o_status
//   config    in         i_cfg_wr_en                i_cfg_wr_data (base_address)
//
// Bad-argument request: the reject state loads the response once the output register is
// free. Walked request: one tree node visited a cycle, at most 2^(SPLIT_LEVELS+1)-1
// (511 at the defaults); the result is loaded once the output register is free. Either
// way the next request waits for that. After reset a clearing pass writes every node
// free while requests are stalled; configuration writes are taken at all times.
// A held response stalls the walker's hand-off but not the taking of the next request.
`default_nettype none
module buddy_allocator_first_fit #(
    parameter int TOTAL_LOG2   = 16,
    parameter int SPLIT_LEVELS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [buddy_pkg::ADDR_W-1:0]  i_cfg_wr_data,
    input  wire logic                          i_req_valid,
    output logic                               o_req_stall,
    input  wire logic [buddy_pkg::OWNER_W-1:0] i_owner_id,
    input  wire logic [buddy_pkg::SIZE_W-1:0]  i_request_size,
    output logic                               o_rsp_valid,
    input  wire logic                          i_rsp_stall,
    output logic      [buddy_pkg::ADDR_W-1:0]  o_block_address,
    output buddy_pkg::t_status                 o_status
);
    import buddy_pkg::*;

    localparam int IDX_W    = SPLIT_LEVELS + 1;
    localparam int LVL_W    = $clog2(SPLIT_LEVELS + 1);
    localparam int BL_W     = $clog2(SIZE_W + 1);
    localparam int MIN_LOG2 = (TOTAL_LOG2 > SPLIT_LEVELS) ? TOTAL_LOG2 - SPLIT_LEVELS : 0;

    typedef enum logic [2:0] {
        T_IDLE   = 3'b001,
        T_WALK   = 3'b010,
        T_REJECT = 3'b100
    } t_top_state;

    t_top_state         r_state, n_state;
    logic [ADDR_W-1:0]  r_base;
    logic [LVL_W-1:0]   r_tgt;
    logic               r_rsp_valid;
    logic [ADDR_W-1:0]  r_block_address;
    t_status            r_status;

    t_walk_ctl          walk_ctl;
    t_walk_sts          walk_sts;
    logic [IDX_W-1:0]   hit_idx;

    logic               req_accept;
    logic               arg_bad;
    logic               out_free;
    logic               load_out;
    logic [SIZE_W-1:0]  size_m1;
    logic [BL_W-1:0]    bit_len;
    logic [5:0]         k6;
    logic [5:0]         tgt6;
    logic [LVL_W-1:0]   req_tgt;
    logic [ADDR_W-1:0]  pos;
    logic [ADDR_W-1:0]  offset;
    logic [ADDR_W-1:0]  res_addr;
    t_status            res_status;

    buddy_walk #(
        .SPLIT_LEVELS (SPLIT_LEVELS)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (walk_ctl),
        .i_tgt     (req_tgt),
        .o_sts     (walk_sts),
        .o_hit_idx (hit_idx)
    );

    assign o_req_stall = !(r_state == T_IDLE && walk_sts.ready);
    assign req_accept  = i_req_valid && !o_req_stall;
    assign out_free    = !r_rsp_valid || !i_rsp_stall;

    assign arg_bad = (i_owner_id == '0) || (i_request_size == '0)
                     || ({16'd0, i_request_size} > (33'd1 << TOTAL_LOG2));

    // round up to a power of two: target level from the bit length of size - 1
    always_comb begin
        size_m1 = i_request_size - 1'b1;
        bit_len = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (size_m1[i]) begin
                bit_len = BL_W'(i + 1);
            end
        end
        k6 = (6'(bit_len) > 6'(MIN_LOG2)) ? 6'(bit_len) : 6'(MIN_LOG2);
        tgt6 = 6'(TOTAL_LOG2) - k6;
        if (tgt6 > 6'(SPLIT_LEVELS)) begin
            tgt6 = 6'(SPLIT_LEVELS);
        end
        req_tgt = LVL_W'(tgt6);
    end

    assign walk_ctl.start = req_accept && !arg_bad;
    assign walk_ctl.ack   = (r_state == T_WALK) && walk_sts.done && out_free;
    assign load_out       = walk_ctl.ack || (r_state == T_REJECT && out_free);

    // drop the leading one of the hit index, then scale by the block size
    assign pos    = ADDR_W'(hit_idx) & ~(32'd1 << r_tgt);
    assign offset = pos << (6'(TOTAL_LOG2) - 6'(r_tgt));

    always_comb begin
        res_addr   = '0;
        res_status = STS_INVALID;
        if (r_state == T_WALK) begin
            if (walk_sts.found) begin
                res_addr   = r_base + offset;
                res_status = STS_OK;
            end else begin
                res_status = STS_NO_SPACE;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE: begin
                if (req_accept) begin
                    n_state = arg_bad ? T_REJECT : T_WALK;
                end
            end
            T_WALK: begin
                if (walk_ctl.ack) begin
                    n_state = T_IDLE;
                end
            end
            T_REJECT: begin
                if (out_free) begin
                    n_state = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_base      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
            if (load_out) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_tgt <= req_tgt;
        end
        if (load_out) begin
            r_block_address <= res_addr;
            r_status        <= res_status;
        end
    end

    assign o_rsp_valid     = r_rsp_valid;
    assign o_block_address = r_block_address;
    assign o_status        = r_status;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && i_rsp_stall) |-> !load_out)
        else $error("held response overwritten");

    a_addr_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_status != STS_OK) |-> (r_block_address == '0))
        else $error("nonzero address on failed request");

    a_walk_only_when_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_sts.done |-> (r_state == T_WALK))
        else $error("walker finished with no request in work");

endmodule
`default_nettype wire

[hw/rtl/buddy_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module buddy_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[hw/rtl/buddy_walk.sv]
// Depth-first tree walker over the node state memory, with the clearing pass after reset.
`default_nettype none
module buddy_walk #(
    parameter int SPLIT_LEVELS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire buddy_pkg::t_walk_ctl              i_ctl,
    input  wire logic [$clog2(SPLIT_LEVELS+1)-1:0] i_tgt,
    output buddy_pkg::t_walk_sts                   o_sts,
    output logic      [SPLIT_LEVELS:0]             o_hit_idx
);
    import buddy_pkg::*;

    localparam int IDX_W = SPLIT_LEVELS + 1;
    localparam int DEPTH = 1 << IDX_W;
    localparam int LVL_W = $clog2(SPLIT_LEVELS + 1);
    localparam int T_W   = $clog2(IDX_W + 1);

    typedef enum logic [3:0] {
        W_CLEAR = 4'b0001,
        W_IDLE  = 4'b0010,
        W_VISIT = 4'b0100,
        W_DONE  = 4'b1000
    } t_walk_state;

    t_walk_state      r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic [LVL_W-1:0] r_tgt, n_tgt;
    logic             r_found, n_found;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_node_st         wr_data;
    logic [IDX_W-1:0] rd_addr;
    t_node_st         rd_data;
    logic [T_W-1:0]   ones_t;

    buddy_ram #(
        .WIDTH ($bits(t_node_st)),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        // position of the lowest zero bit: number of levels to climb on backtrack
        ones_t = T_W'(IDX_W);
        for (int i = IDX_W - 1; i >= 0; i--) begin
            if (!r_idx[i]) begin
                ones_t = T_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_lvl   = r_lvl;
        n_tgt   = r_tgt;
        n_found = r_found;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = NODE_FREE;
        rd_addr = IDX_W'(1);
        unique case (r_state)
            W_CLEAR: begin
                wr_en = 1'b1;
                if (r_idx == {IDX_W{1'b1}}) begin
                    n_state = W_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            W_IDLE: begin
                // root read goes out now, data arrives in the first visit
                if (i_ctl.start) begin
                    n_state = W_VISIT;
                    n_idx   = IDX_W'(1);
                    n_lvl   = '0;
                    n_tgt   = i_tgt;
                end
            end
            W_VISIT: begin
                if (rd_data == NODE_FREE && r_lvl == r_tgt) begin
                    wr_en   = 1'b1;
                    wr_data = NODE_OCCUPIED;
                    n_found = 1'b1;
                    n_state = W_DONE;
                end else if ((rd_data == NODE_FREE || rd_data == NODE_SPLIT)
                             && r_lvl < r_tgt) begin
                    // split a free block, or pass a split one, and keep going into the left half
                    if (rd_data == NODE_FREE) begin
                        wr_en   = 1'b1;
                        wr_data = NODE_SPLIT;
                    end
                    n_idx   = {r_idx[IDX_W-2:0], 1'b0};
                    n_lvl   = r_lvl + 1'b1;
                    rd_addr = n_idx;
                end else if (int'(ones_t) > int'(r_lvl)) begin
                    // rightmost path exhausted back to the root
                    n_found = 1'b0;
                    n_state = W_DONE;
                end else begin
                    // climb past right children, then step to the right sibling
                    n_idx   = (r_idx >> ones_t) | IDX_W'(1);
                    n_lvl   = r_lvl - LVL_W'(ones_t);
                    rd_addr = n_idx;
                end
            end
            W_DONE: begin
                if (i_ctl.ack) begin
                    n_state = W_IDLE;
                end
            end
            default: begin
                n_state = W_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_CLEAR;
            r_idx   <= '0;
            r_lvl   <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_lvl   <= n_lvl;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt <= n_tgt;
    end

    assign o_sts.ready = (r_state == W_IDLE);
    assign o_sts.done  = (r_state == W_DONE);
    assign o_sts.found = r_found;
    assign o_hit_idx   = r_idx;

    // the final write of a walk may meet the idle root read; the result of that read is unused
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == W_VISIT && wr_en && n_state == W_VISIT) |-> (wr_addr != rd_addr))
        else $error("state memory read and write hit the same node");

    a_lvl_matches_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == W_VISIT) |-> ((r_idx >> r_lvl) == IDX_W'(1) && r_lvl <= r_tgt))
        else $error("walker level out of step with node index");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (r_state == W_IDLE))
        else $error("walk started while walker busy");

    a_hit_at_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == W_VISIT && n_state == W_DONE && n_found) |=>
            ((r_idx >> r_tgt) == IDX_W'(1)))
        else $error("hit node not at the target level");

endmodule
`default_nettype wire
